/* sv/box_blur_3x3_edge_mean_unit_macros.svh */
// Assertion macros shared by the box blur RTL.
// Included by modules that carry concurrent checks; needs no other file.
`ifndef BOX_BLUR_3X3_EDGE_MEAN_UNIT_MACROS_SVH
`define BOX_BLUR_3X3_EDGE_MEAN_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define BBEM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define BBEM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BBEM_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define BBEM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* sv/bbem_pkg.sv */
// Package for the 3x3 box blur: frame geometry, widths, codes and the
// constant-reciprocal mean divider. No dependencies.
package bbem_pkg;

  // frame geometry
  localparam int FRAME_WIDTH  = 32;
  localparam int FRAME_HEIGHT = 32;
  localparam int COL_W = (FRAME_WIDTH  > 2) ? $clog2(FRAME_WIDTH)  : 1;
  localparam int ROW_W = (FRAME_HEIGHT > 2) ? $clog2(FRAME_HEIGHT) : 1;

  // payload widths
  localparam int PIX_W = 8;
  localparam int POS_W = 5;
  localparam int SUM_W = PIX_W + 4;   // nine pixels
  localparam int CNT_W = 4;

  // neighbour counts: corner, edge, interior
  localparam logic [CNT_W-1:0] CNT_CORNER = 4'd4;
  localparam logic [CNT_W-1:0] CNT_EDGE   = 4'd6;
  localparam logic [CNT_W-1:0] CNT_FULL   = 4'd9;

  // floor(s/n) = (s * ceil(2^k/n)) >> k, exact for s below 2^k / error
  localparam int CORNER_SHIFT = 2;
  localparam int RECIP_SHIFT  = 15;
  localparam int RECIP_W      = 13;
  localparam logic [RECIP_W-1:0] RECIP_EDGE = 13'd5462;
  localparam logic [RECIP_W-1:0] RECIP_FULL = 13'd3641;
  localparam int PROD_W = SUM_W + RECIP_W;

  // line store entry: rows r-2 and r-1 of one column
  typedef struct packed {
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] middle;
  } line_pair_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_SUM,
    S_DIV
  } bbem_state_t;

  // floor of sum / cnt for the three neighbour counts
  function automatic logic [PIX_W-1:0] mean_div(input logic [SUM_W-1:0] sum,
                                                input logic [CNT_W-1:0] cnt);
    logic [PROD_W-1:0] prod;
    logic [PIX_W-1:0]  q;
    prod = '0;
    q    = '0;
    case (cnt)
      CNT_CORNER: begin
        q = PIX_W'(sum >> CORNER_SHIFT);
      end
      CNT_EDGE: begin
        prod = PROD_W'(sum) * PROD_W'(RECIP_EDGE);
        q    = prod[RECIP_SHIFT +: PIX_W];
      end
      default: begin
        prod = PROD_W'(sum) * PROD_W'(RECIP_FULL);
        q    = prod[RECIP_SHIFT +: PIX_W];
      end
    endcase
    return q;
  endfunction

endpackage

/* sv/bbem_if.sv */
// Valid/ready channel interfaces for the box blur: pixel input and results.
// Depends on bbem_pkg.
interface bbem_pix_if
  import bbem_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface bbem_res_if
  import bbem_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic [POS_W-1:0] out_row;
  logic [POS_W-1:0] out_col;
  logic             run_last;

  modport source (output valid, output pixel_out, output out_row, output out_col,
                  output run_last, input ready);
  modport sink   (input valid, input pixel_out, input out_row, input out_col,
                  input run_last, output ready);
endinterface

/* sv/bbem_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module bbem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/box_blur_3x3_edge_mean_unit.sv */
// Channel   | Dir | Payload                                    | Handshake
// ----------+-----+--------------------------------------------+-------------
// pixels    | in  | pixel_in[7:0]                              | valid/ready
// results   | out | pixel_out[7:0] out_row[4:0] out_col[4:0]   | valid/ready
//           |     | run_last                                   |
//
// One pixel at a time: a pixel passes S_IDLE and S_LOAD, then S_SUM and
// S_DIV once per result it yields (n up to 4); S_DIV holds while the output
// register is full. The pace is set by the read-modify-write of the line
// store RAM and the single shared sum/divide unit, one result at a time.
// A waiting result sits in the output register; a new pixel is still taken.
// Reset clears counters, window and control; the line store is not cleared.
// Depends on bbem_pkg, bbem_if, bbem_ram and the assertion macro header.
`include "box_blur_3x3_edge_mean_unit_macros.svh"

module box_blur_3x3_edge_mean_unit
  import bbem_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  bbem_pix_if.sink      pixels,
  bbem_res_if.source    results
);

  bbem_state_t state, state_next;

  // position of the next input pixel
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] col_count;

  // pixel being worked on and its position
  logic [PIX_W-1:0] px_q;
  logic [ROW_W-1:0] r_q;
  logic [COL_W-1:0] c_q;
  logic             last_row_q;

  // 3x3 window, [row][col], column 2 is newest
  logic [PIX_W-1:0] win [3][3];

  // pending results: centre (1,1) (1,2) (2,1) (2,2) in emission order
  logic [3:0] pend;

  // sum stage registers
  logic [SUM_W-1:0] sum_q;
  logic [CNT_W-1:0] cnt_q;
  logic [POS_W-1:0] tag_row_q;
  logic [POS_W-1:0] tag_col_q;
  logic             last_q;

  // output register
  logic             out_valid;
  logic [PIX_W-1:0] out_pix;
  logic [POS_W-1:0] out_row_q;
  logic [POS_W-1:0] out_col_q;
  logic             out_last;

  // line store RAM
  logic             ram_we;
  logic             ram_re;
  line_pair_t       ram_wdata;
  logic [2*PIX_W-1:0] ram_rdata;
  line_pair_t       rd_pair;

  logic in_fire;
  logic out_free;
  logic last_col_in;
  logic last_row_in;

  // sum unit signals
  logic [1:0]       sel;
  logic [3:0]       pend_rest;
  logic [2:0]       rv;
  logic [2:0]       cv;
  logic [SUM_W-1:0] sum_next;
  logic [CNT_W-1:0] cnt_next;
  logic [3:0]       pend_load;

  assign in_fire  = pixels.valid && pixels.ready;
  assign out_free = !out_valid || results.ready;
  assign rd_pair  = line_pair_t'(ram_rdata);

  assign last_col_in = (col_count == COL_W'(FRAME_WIDTH - 1));
  assign last_row_in = (row_count == ROW_W'(FRAME_HEIGHT - 1));

  bbem_ram #(
    .WIDTH ($bits(line_pair_t)),
    .DEPTH (FRAME_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (c_q),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (col_count),
    .rdata (ram_rdata)
  );

  // line store shifts up one row in the column just read
  assign ram_wdata.upper  = rd_pair.middle;
  assign ram_wdata.middle = px_q;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and control
  always_comb begin
    state_next   = state;
    pixels.ready = 1'b0;
    ram_re       = 1'b0;
    ram_we       = 1'b0;
    case (state)
      S_IDLE: begin
        pixels.ready = 1'b1;
        ram_re       = pixels.valid;
        if (pixels.valid) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        ram_we     = 1'b1;
        state_next = (pend_load != 4'b0000) ? S_SUM : S_IDLE;
      end
      S_SUM: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        if (out_free) begin
          state_next = (pend != 4'b0000) ? S_SUM : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // results owed by the pixel in hand
  assign last_row_q = (r_q == ROW_W'(FRAME_HEIGHT - 1));

  assign pend_load = {
    last_row_q && (c_q == COL_W'(FRAME_WIDTH - 1)),
    last_row_q && (c_q != '0),
    (r_q != '0) && (c_q == COL_W'(FRAME_WIDTH - 1)),
    (r_q != '0) && (c_q != '0)
  };

  // pick the next result and sum its in-frame neighbours
  always_comb begin
    sel = 2'd3;
    if (pend[0]) begin
      sel = 2'd0;
    end else if (pend[1]) begin
      sel = 2'd1;
    end else if (pend[2]) begin
      sel = 2'd2;
    end
    pend_rest = pend & ~(4'b0001 << sel);
    // window rows/columns that fall inside the frame
    rv = {1'b1, r_q != '0, r_q > ROW_W'(1)};
    cv = {1'b1, c_q != '0, c_q > COL_W'(1)};
    // a centre on window row/col 2 drops row/col 0
    if (sel[1]) begin
      rv[0] = 1'b0;
    end
    if (sel[0]) begin
      cv[0] = 1'b0;
    end
    sum_next = '0;
    cnt_next = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (rv[i] && cv[j]) begin
          sum_next = sum_next + SUM_W'(win[i][j]);
          cnt_next = cnt_next + CNT_W'(1);
        end
      end
    end
  end

  // counters, window, and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
      pend      <= '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= '0;
        end
      end
    end else begin
      if (in_fire) begin
        if (last_col_in) begin
          col_count <= '0;
          row_count <= last_row_in ? '0 : row_count + ROW_W'(1);
        end else begin
          col_count <= col_count + COL_W'(1);
        end
      end
      if (state == S_LOAD) begin
        for (int i = 0; i < 3; i++) begin
          win[i][0] <= win[i][1];
          win[i][1] <= win[i][2];
        end
        win[0][2] <= rd_pair.upper;
        win[1][2] <= rd_pair.middle;
        win[2][2] <= px_q;
        pend      <= pend_load;
      end
      if (state == S_SUM) begin
        pend <= pend_rest;
      end
    end
  end

  // captured pixel and sum stage payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      px_q <= pixels.pixel_in;
      r_q  <= row_count;
      c_q  <= col_count;
    end
    if (state == S_SUM) begin
      sum_q     <= sum_next;
      cnt_q     <= cnt_next;
      tag_row_q <= POS_W'(sel[1] ? r_q : r_q - ROW_W'(1));
      tag_col_q <= POS_W'(sel[0] ? c_q : c_q - COL_W'(1));
      last_q    <= (pend_rest == 4'b0000);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DIV && out_free) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DIV && out_free) begin
      out_pix   <= mean_div(sum_q, cnt_q);
      out_row_q <= tag_row_q;
      out_col_q <= tag_col_q;
      out_last  <= last_q;
    end
  end

  assign results.valid     = out_valid;
  assign results.pixel_out = out_pix;
  assign results.out_row   = out_row_q;
  assign results.out_col   = out_col_q;
  assign results.run_last  = out_last;

  // checks
  `BBEM_ASSERT_NOW(a_cnt_legal, clk, rst, state == S_DIV, cnt_q == CNT_CORNER || cnt_q == CNT_EDGE || cnt_q == CNT_FULL, "neighbour count not 4 6 or 9")
  `BBEM_ASSERT_NOW(a_last_drains, clk, rst, state == S_DIV && last_q, pend == 4'b0000, "run end flagged with results pending")
  `BBEM_ASSERT_NOW(a_rise_from_div, clk, rst, $rose(out_valid), $past(state == S_DIV), "result appeared without divide step")
  `BBEM_ASSERT_NEXT(a_accept_loads, clk, rst, in_fire, state == S_LOAD && !ram_re, "accepted pixel not followed by line store update")
  `BBEM_ASSERT_NOW(a_col_range, clk, rst, 1'b1, 32'(col_count) < FRAME_WIDTH, "column counter out of frame")

endmodule

/* tb/box_mean_check.sv */
// Watches the pixel and result channels of the 3x3 box blur, predicts every
// filtered pixel from the accepted input stream and compares field by field.
// Depends on bbem_pkg and the channel interfaces in bbem_if.
`timescale 1ns / 100ps

module box_mean_check
  import bbem_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  bbem_pix_if         pix,
  bbem_res_if         res,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned checked,
  output int unsigned frames_done
);

  // one filtered pixel as it should leave the block
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } blur_res_t;

  // predictor state: two stored rows, sliding window, raster position
  logic [PIX_W-1:0] line_upper  [FRAME_WIDTH];
  logic [PIX_W-1:0] line_middle [FRAME_WIDTH];
  logic [PIX_W-1:0] win [3][3];
  int               row_pos;
  int               col_pos;
  blur_res_t        blur_q [$];

  initial begin
    fail_count  = 0;
    pending     = 0;
    checked     = 0;
    frames_done = 0;
  end

  // floor mean of the in-frame neighbours around window cell (cr, cc);
  // window cell (i, j) holds frame pixel (r - 2 + i, c - 2 + j)
  function automatic int window_mean(input int r, input int c, input int cr, input int cc);
    int sum;
    int cnt;
    int wr;
    int wc;
    sum = 0;
    cnt = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        wr = cr + dr;
        wc = cc + dc;
        if (wr >= 0 && wr < 3 && wc >= 0 && wc < 3 &&
            r - 2 + wr >= 0 && r - 2 + wr < FRAME_HEIGHT &&
            c - 2 + wc >= 0 && c - 2 + wc < FRAME_WIDTH) begin
          sum += int'(win[wr][wc]);
          cnt++;
        end
      end
    end
    return (cnt == 0) ? 0 : sum / cnt;
  endfunction

  function automatic blur_res_t make_res(input int mean, input int r, input int c);
    blur_res_t e;
    e.pix  = PIX_W'(mean);
    e.row  = POS_W'(r);
    e.col  = POS_W'(c);
    e.last = 1'b0;
    return e;
  endfunction

  // shift the window, update the line stores and queue what this pixel releases
  task automatic predict_blur(input logic [PIX_W-1:0] px);
    blur_res_t batch [$];
    int        r;
    int        c;
    bit        end_col;
    bit        end_row;
    r = row_pos;
    c = col_pos;
    end_col = (c == FRAME_WIDTH - 1);
    end_row = (r == FRAME_HEIGHT - 1);
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = line_upper[c];
    win[1][2] = line_middle[c];
    win[2][2] = px;
    line_upper[c]  = line_middle[c];
    line_middle[c] = px;

    if (r >= 1 && c >= 1) batch.push_back(make_res(window_mean(r, c, 1, 1), r - 1, c - 1));
    if (r >= 1 && end_col) batch.push_back(make_res(window_mean(r, c, 1, 2), r - 1, c));
    if (end_row && c >= 1) batch.push_back(make_res(window_mean(r, c, 2, 1), r, c - 1));
    if (end_row && end_col) batch.push_back(make_res(window_mean(r, c, 2, 2), r, c));
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[k]) blur_q.push_back(batch[k]);

    // raster position, wrapping into the next frame
    if (end_col) begin
      col_pos = 0;
      if (end_row) begin
        row_pos = 0;
        frames_done++;
      end else begin
        row_pos = r + 1;
      end
    end else begin
      col_pos = c + 1;
    end
  endtask

  // sampled mid-cycle: the values seen here are those at the next rising edge
  always @(negedge clk) begin
    blur_res_t want;
    if (rst) begin
      foreach (win[i, j]) win[i][j] = '0;
      foreach (line_upper[i]) begin
        line_upper[i]  = '0;
        line_middle[i] = '0;
      end
      row_pos = 0;
      col_pos = 0;
      blur_q.delete();
    end else begin
      // result transaction first, so nothing can match a same-edge prediction
      if (res.valid && res.ready) begin
        if (blur_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result pix=%0d row=%0d col=%0d last=%0b", $realtime,
                     res.pixel_out, res.out_row, res.out_col, res.run_last);
          fail_count++;
        end else begin
          want = blur_q.pop_front();
          checked++;
          if (res.pixel_out !== want.pix || res.out_row !== want.row ||
              res.out_col !== want.col || res.run_last !== want.last) begin
            if (fail_count < 10)
              $display("%0t: mismatch exp pix=%0d row=%0d col=%0d last=%0b, got pix=%0d row=%0d col=%0d last=%0b",
                       $realtime, want.pix, want.row, want.col, want.last,
                       res.pixel_out, res.out_row, res.out_col, res.run_last);
            fail_count++;
          end
        end
      end
      if (pix.valid && pix.ready) predict_blur(pix.pixel_in);
    end
    pending = blur_q.size();
  end

endmodule

/* tb/testbench.sv */
// Top of the box blur testbench: clock, reset, pixel stream and result drain
// with random idling, plus the verdict. Depends on bbem_pkg, bbem_if, the
// box blur RTL and box_mean_check.
`timescale 1ns / 100ps

module testbench;
  import bbem_pkg::*;

  // the top fourteen rows or so: first-row silence, top corners, side edges
  localparam int PIXEL_COUNT = 450;
  localparam int DIRECTED_N  = 25;
  localparam int HOLD_AFTER  = 150;   // results taken before the long hold-off
  localparam int HOLD_CYCLES = 400;
  localparam logic [PIX_W-1:0] DIRECTED_PX [DIRECTED_N] = '{
    8'd0,   8'd255, 8'd1,   8'd2,   8'd4,   8'd8,   8'd16,  8'd32,  8'd64,
    8'd128, 8'd254, 8'd253, 8'd251, 8'd247, 8'd239, 8'd223, 8'd191, 8'd127,
    8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   8'd170
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned frames_done;
  int unsigned sent;
  bit          pix_eager;
  bit          res_eager;

  bbem_pix_if pix_ch ();
  bbem_res_if res_ch ();

  box_blur_3x3_edge_mean_unit uut (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pix_ch),
    .results (res_ch)
  );

  box_mean_check mean_check (
    .clk         (clk),
    .rst         (rst),
    .pix         (pix_ch),
    .res         (res_ch),
    .fail_count  (fail_count),
    .pending     (pending),
    .checked     (checked),
    .frames_done (frames_done)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // wait before a transaction; eager stretches run with no idling at all
  function automatic int pick_wait(input bit eager);
    return eager ? 0 : int'($urandom_range(0, 10));
  endfunction

  // pixel content by row flavour: saturated, dark, two-level, narrow bands, random
  function automatic logic [PIX_W-1:0] row_pixel(input int unsigned mode);
    case (mode)
      1:       return 8'd255;
      2:       return 8'd0;
      3:       return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
      4:       return PIX_W'($urandom_range(224, 255));
      5:       return PIX_W'($urandom_range(0, 31));
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // pixel stream, then drain and verdict
  initial begin : stimulus
    int unsigned      gap;
    int unsigned      mode;
    logic [PIX_W-1:0] px;
    sent = 0;
    mode = 0;
    pix_eager = 1'b0;
    pix_ch.valid    <= 1'b0;
    pix_ch.pixel_in <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int n = 0; n < PIXEL_COUNT; n++) begin
      if (n % 50 == 0) pix_eager = ($urandom_range(0, 3) == 0);
      if (n < DIRECTED_N) begin
        px = DIRECTED_PX[n];
      end else begin
        if (n % FRAME_WIDTH == 0 || n == DIRECTED_N) mode = $urandom_range(0, 7);
        px = row_pixel(mode);
      end
      gap = pick_wait(pix_eager);
      if (gap > 0) begin
        pix_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pix_ch.valid    <= 1'b1;
      pix_ch.pixel_in <= px;
      @(negedge clk);
      while (!pix_ch.ready) @(negedge clk);
      @(posedge clk);
      sent++;
    end
    pix_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Streamed %0d pixels through %0d frame wrap(s); %0d filtered pixels checked",
             sent, frames_done, checked);
    $display("Covered first-row silence, edges, corners, saturated windows and a long output stall");
    if (fail_count == 0) begin
      $display("box_blur_3x3_edge_mean_unit verification clean");
    end else begin
      $display("box_blur_3x3_edge_mean_unit verification failed");
    end
    $finish;
  end

  // result drain with random stalls and one long hold-off to back up the block
  initial begin : drain
    int unsigned stall;
    int unsigned taken;
    taken = 0;
    res_eager = 1'b0;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = (taken == HOLD_AFTER) ? HOLD_CYCLES : pick_wait(res_eager);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(negedge clk);
      while (!res_ch.valid) @(negedge clk);
      @(posedge clk);
      taken++;
      if (taken % 40 == 0) res_eager = ($urandom_range(0, 3) == 0);
    end
  end

  // hard stop well beyond the slowest legal run
  initial begin : watchdog
    #1000000;
    $display("box_blur_3x3_edge_mean_unit verification failed");
    $finish;
  end

endmodule
